// ===== rtl/temp_scratchpad_decoder_macros.svh =====
`ifndef TEMP_SCRATCHPAD_DECODER_MACROS_SVH
`define TEMP_SCRATCHPAD_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsd_pkg.sv =====
`timescale 1ns / 1ps
package tsd_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned PosWidth   = 4;

  // Byte positions inside the scratchpad frame
  localparam logic [PosWidth-1:0] PosTempLsb  = 4'd0;
  localparam logic [PosWidth-1:0] PosTempMsb  = 4'd1;
  localparam logic [PosWidth-1:0] PosConfig   = 4'd4;
  localparam logic [PosWidth-1:0] PosCountRem = 4'd6;
  localparam logic [PosWidth-1:0] PosCountPer = 4'd7;
  localparam logic [PosWidth-1:0] PosCrc      = PosWidth'(FrameBytes - 1);

  localparam logic [7:0] CrcPoly = 8'h8C;

  localparam logic [7:0] ResMask  = 8'h60;
  localparam logic [7:0] Res9Bit  = 8'h00;
  localparam logic [7:0] Res10Bit = 8'h20;
  localparam logic [7:0] Res11Bit = 8'h40;

  localparam logic [7:0]  CountPerNominal = 8'h10;
  localparam logic [15:0] TempIntMask     = 16'hFFF0;
  localparam logic [15:0] CountBias       = 16'd12;

  // Everything the back end needs to finish one frame
  typedef struct packed {
    logic [7:0] temp_lsb;
    logic [7:0] temp_msb;
    logic [7:0] config_byte;
    logic [7:0] count_remain;
    logic [7:0] count_per_c;
    logic       family;
    logic       crc_good;
  } tsd_cmd_t;

endpackage

// ===== rtl/tsd_intf.sv =====
`timescale 1ns / 1ps
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface tsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_sixteenths;
  logic               crc_good;

  modport source (output valid, output temp_sixteenths, output crc_good, input ready);
  modport sink (input valid, input temp_sixteenths, input crc_good, output ready);
endinterface

interface tsd_cfg_if;
  logic valid;
  logic ready;
  logic sensor_family;

  modport source (output valid, output sensor_family, input ready);
  modport sink (input valid, input sensor_family, output ready);
endinterface

// ===== rtl/tsd_fifo.sv =====
`timescale 1ns / 1ps
module tsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/tsd_front.sv =====
`timescale 1ns / 1ps
module tsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsd_in_if.sink            in_i,
  tsd_cfg_if.sink           cfg_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output tsd_pkg::tsd_cmd_t cmd_o
);
  import tsd_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]          crc_q, crc_d, crc_eff, crc_next;
  logic                family_q;
  logic [7:0]          lsb_q, msb_q, cfgb_q, crem_q, cper_q;
  logic                accept, last_byte;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  assign cfg_i.ready = 1'b1;

  // Only a byte that arrives while the position is at the check byte needs room in the queue
  assign in_i.ready = cmd_ready_i || (pos_q < PosCrc);
  assign accept     = in_i.valid && in_i.ready;

  assign pos_eff   = in_i.frame_start ? '0 : pos_q;
  assign crc_eff   = in_i.frame_start ? '0 : crc_q;
  assign last_byte = (pos_eff >= PosCrc);
  assign crc_next  = crc_step(crc_eff, in_i.rx_byte);

  assign cmd_valid_o        = accept && last_byte;
  assign cmd_o.temp_lsb     = lsb_q;
  assign cmd_o.temp_msb     = msb_q;
  assign cmd_o.config_byte  = cfgb_q;
  assign cmd_o.count_remain = crem_q;
  assign cmd_o.count_per_c  = cper_q;
  assign cmd_o.family       = family_q;
  assign cmd_o.crc_good     = (crc_eff == in_i.rx_byte);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (accept) begin
      if (last_byte) begin
        pos_d = '0;
        crc_d = '0;
      end else begin
        pos_d = pos_eff + 1'b1;
        crc_d = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= '0;
      family_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      if (cfg_i.valid && cfg_i.ready) begin
        family_q <= cfg_i.sensor_family;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (pos_eff)
        PosTempLsb:  lsb_q  <= in_i.rx_byte;
        PosTempMsb:  msb_q  <= in_i.rx_byte;
        PosConfig:   cfgb_q <= in_i.rx_byte;
        PosCountRem: crem_q <= in_i.rx_byte;
        PosCountPer: cper_q <= in_i.rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tsd_back.sv =====
`timescale 1ns / 1ps
module tsd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  tsd_pkg::tsd_cmd_t cmd_i,
  tsd_out_if.source         out_o
);
  import tsd_pkg::*;

  logic        out_valid_q;
  logic [15:0] temp_q, temp_d;
  logic        crc_q;
  logic [15:0] raw, shifted;
  logic [7:0]  res;

  assign cmd_ready_o = !out_valid_q || out_o.ready;

  always_comb begin
    raw     = {cmd_i.temp_msb, cmd_i.temp_lsb};
    shifted = raw << 3;
    res     = cmd_i.config_byte & ResMask;
    temp_d  = raw;
    if (cmd_i.family) begin
      temp_d = shifted;
      if (cmd_i.count_per_c == CountPerNominal) begin
        // integer part plus three quarters of a degree, less the remaining count
        temp_d = (shifted & TempIntMask) + CountBias - {8'h00, cmd_i.count_remain};
      end
    end else begin
      case (res)
        Res9Bit:  temp_d = raw & 16'hFFF8;
        Res10Bit: temp_d = raw & 16'hFFFC;
        Res11Bit: temp_d = raw & 16'hFFFE;
        default:  temp_d = raw;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      temp_q <= temp_d;
      crc_q  <= cmd_i.crc_good;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.temp_sixteenths = temp_q;
  assign out_o.crc_good        = crc_q;

endmodule

// ===== rtl/temp_scratchpad_decoder.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                              Notes
// in_i      in   rx_byte[7:0], frame_start            one scratchpad byte per item
// out_o     out  temp_sixteenths[15:0] s, crc_good    one item per nine bytes
// cfg_i     in   sensor_family                        write only while idle
//
// Takes one byte per cycle unless the queue is full at a check byte; the front end's CRC update sets the cycle time.
// The ninth byte's command is written into the queue, then registered at the back end's output.
// Reset clears byte position, CRC, queue, output valid and the family register.
// An output stall fills the command queue; only bytes at the check-byte position then wait for room.
module temp_scratchpad_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsd_in_if.sink    in_i,
  tsd_cfg_if.sink   cfg_i,
  tsd_out_if.source out_o
);
  import tsd_pkg::*;

  logic     fr_valid, fr_ready;
  tsd_cmd_t fr_cmd;
  logic     bk_valid, bk_ready;
  tsd_cmd_t bk_cmd;

  tsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  tsd_fifo #(
    .WIDTH ($bits(tsd_cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd)
  );

  tsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/tsd_checker.sv =====
`timescale 1ns / 1ps
`include "temp_scratchpad_decoder_macros.svh"
module tsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_temp_i,
  input logic        out_crc_i
);

  `TSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `TSD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_temp_i) && $stable(out_crc_i), "result changed while stalled")
  // an empty output side means the queue has room, so the input is always ready
  `TSD_ASSERT_NOW(a_in_ready_idle, clk_i, rst_ni, !out_valid_i, in_ready_i, "input stalled with idle output")
  // a fresh result traces back to an accepted byte through the queue and the output register
  `TSD_ASSERT_NOW(a_out_cause, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without a byte")

endmodule

bind temp_scratchpad_decoder tsd_checker u_tsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_temp_i  (out_o.temp_sixteenths),
  .out_crc_i   (out_o.crc_good)
);

// ===== sim/temp_scratchpad_decoder_tb.sv =====
`timescale 1ns / 1ps
module temp_scratchpad_decoder_tb;
  import tsd_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 10;
  localparam int ItemsPerHalf  = 75;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               good;
  } reading_t;

  class reading_scoreboard;
    bit         family;
    logic [7:0] crc;
    logic [3:0] pos;
    logic [7:0] lo, hi, res_byte, count_rem, count_per;
    reading_t   readings_due[$];
    int         errors;

    function new();
      family    = 1'b0;
      crc       = 8'h00;
      pos       = 4'd0;
      lo        = 8'h00;
      hi        = 8'h00;
      res_byte  = 8'h00;
      count_rem = 8'h00;
      count_per = 8'h00;
      errors    = 0;
    endfunction

    // Dallas CRC-8, reflected polynomial, LSB first
    function logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
      c = c ^ b;
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      return c;
    endfunction

    function logic [15:0] decoded();
      logic [15:0] raw;
      raw = {hi, lo};
      if (family) begin
        raw = raw << 3;
        if (count_per == CountPerNominal)
          raw = (raw & TempIntMask) + CountBias - {8'h00, count_rem};
      end else begin
        // undefined low bits are zeroed by resolution
        case (res_byte & ResMask)
          Res9Bit:  raw = raw & 16'hFFF8;
          Res10Bit: raw = raw & 16'hFFFC;
          Res11Bit: raw = raw & 16'hFFFE;
          default: ;
        endcase
      end
      return raw;
    endfunction

    function void take_byte(logic [7:0] b, bit start);
      reading_t r;
      if (start) begin
        pos = 4'd0;
        crc = 8'h00;
      end
      if (pos >= PosCrc) begin
        r.temp = decoded();
        r.good = (crc == b);
        readings_due.push_back(r);
        pos = 4'd0;
        crc = 8'h00;
      end else begin
        case (pos)
          PosTempLsb:  lo = b;
          PosTempMsb:  hi = b;
          PosConfig:   res_byte = b;
          PosCountRem: count_rem = b;
          PosCountPer: count_per = b;
          default: ;
        endcase
        crc = crc_byte(crc, b);
        pos = pos + 4'd1;
      end
    endfunction

    function void match_reading(logic signed [15:0] t, logic g);
      reading_t r;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading temp %0d crc_good %0b", $time, t, g);
        errors++;
        return;
      end
      r = readings_due.pop_front();
      if (t !== r.temp) begin
        $display("%0t: temp_sixteenths expected %0d actual %0d", $time,
                 $signed(r.temp), t);
        errors++;
      end
      if (g !== r.good) begin
        $display("%0t: crc_good expected %0b actual %0b", $time, r.good, g);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tsd_in_if  in_if ();
  tsd_cfg_if cfg_if ();
  tsd_out_if out_if ();

  reading_scoreboard sb;
  int send_idle;
  int recv_idle;
  int items_sent;
  int quiet_cycles;

  temp_scratchpad_decoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.match_reading(out_if.temp_sixteenths, out_if.crc_good);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("%0t: watchdog expired", $time);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit s);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.rx_byte     = b;
    in_if.frame_start = s;
    do @(posedge clk); while (!in_if.ready);
    sb.take_byte(b, s);
    items_sent++;
    @(negedge clk);
  endtask

  // fb[8] is the CRC byte; cut < 9 leaves a partial frame, stray adds
  // frame_start on some later bytes at random
  task automatic send_frame(input logic [8:0][7:0] fb, input bit fix_crc, input int cut,
                            input bit lead_start, input bit stray);
    logic [7:0] c;
    c = 8'h00;
    for (int k = 0; k < 8; k++) c = sb.crc_byte(c, fb[k]);
    if (fix_crc) fb[8] = c;
    for (int k = 0; k < cut; k++)
      send_byte(fb[k], (k == 0) ? lead_start : (stray && $urandom_range(7) == 0));
  endtask

  task automatic send_random_frame();
    logic [8:0][7:0] fb;
    int kind;
    for (int k = 0; k < 9; k++) fb[k] = 8'($urandom_range(255));
    case ($urandom_range(7))
      0: fb[1] = 8'h7F;
      1: fb[1] = 8'h80;
      2: fb[1] = 8'hFF;
      3: fb[1] = 8'h00;
      default: ;
    endcase
    case ($urandom_range(5))
      0: fb[0] = 8'hFF;
      1: fb[0] = 8'h00;
      default: ;
    endcase
    if ($urandom_range(1)) fb[7] = CountPerNominal;
    if ($urandom_range(1)) fb[6] = 8'($urandom_range(16));
    kind = $urandom_range(9);
    // mostly clean frames; some truncated, unmarked, with stray starts or a random CRC byte
    send_frame(fb, $urandom_range(9) != 0, (kind == 0) ? $urandom_range(1, 8) : 9,
               kind != 1, kind == 2);
  endtask

  task automatic write_family(input bit f);
    cfg_if.valid         = 1'b1;
    cfg_if.sensor_family = f;
    do @(posedge clk); while (!cfg_if.ready);
    sb.family = f;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.readings_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int half_start;
    sb                   = new();
    send_idle            = 0;
    recv_idle            = 0;
    items_sent           = 0;
    quiet_cycles         = 0;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.rx_byte        = 8'h00;
    in_if.frame_start    = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.sensor_family = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle = 36; recv_idle = 74; end
        1: begin send_idle = 74; recv_idle = 36; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int fam = 0; fam < 2; fam++) begin
        // sender holds off until every reading is out, then reconfigures
        drain();
        write_family(fam[0]);
        if (p == 0 && fam == 0) begin
          send_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                     1'b1, 9, 1'b1, 1'b0);
          // partial frame, dropped by the next frame_start
          send_frame({8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h60, 8'hFF, 8'hFF, 8'h7F, 8'h80},
                     1'b1, 4, 1'b1, 1'b0);
          send_frame({8'h00, 8'h10, 8'h0C, 8'hFF, 8'h20, 8'h00, 8'h00, 8'h07, 8'h7F},
                     1'b1, 9, 1'b1, 1'b0);
          // follows a complete frame with no frame_start, bad CRC
          send_frame({8'hA5, 8'hFF, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'hFC, 8'h81},
                     1'b0, 9, 1'b0, 1'b0);
        end
        half_start = items_sent;
        while (items_sent - half_start < ItemsPerHalf) send_random_frame();
        in_if.valid = 1'b0;
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tsd_pkg.sv
rtl/tsd_intf.sv
rtl/tsd_fifo.sv
rtl/tsd_front.sv
rtl/tsd_back.sv
rtl/temp_scratchpad_decoder.sv
rtl/tsd_checker.sv
sim/temp_scratchpad_decoder_tb.sv
